// File: src/llsa_pkg.sv
`timescale 1ns / 1ps

package llsa_pkg;

  // Defaults for the top-level parameters.
  localparam int SERVERS_DEF   = 64;
  localparam int TIME_BITS_DEF = 32;

  // Fixed field widths.
  localparam int MODE_W    = 2;
  localparam int SRV_W     = 6;
  localparam int IN_TIME_W = 32;
  localparam int LOAD_W    = 16;
  localparam int FIN_W     = 48;
  localparam int CFG_W     = 7;

  localparam logic [CFG_W-1:0]  CFG_RESET = 7'd64;
  localparam logic [LOAD_W-1:0] LOAD_MAX  = '1;
  localparam logic [FIN_W-1:0]  FIN_MAX   = '1;

  // Event codes; the fourth code is answered with an error result.
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ARRIVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEPART = 2'd2;

  typedef struct packed {
    logic in_ready;
    logic in_take;
    logic cnt_zero;
    logic cnt_inc;
    logic clr_wr;
    logic scan_rd;
    logic dep_calc;
    logic finish;
  } llsa_cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic [MODE_W-1:0] mode;
    logic              cnt_last_all;
    logic              cnt_last_use;
    logic              out_free;
  } llsa_sts_t;

endpackage

// File: src/llsa_in_if.sv
`timescale 1ns / 1ps

interface llsa_in_if;
  import llsa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [SRV_W-1:0]     server;
  logic [IN_TIME_W-1:0] start_time;
  logic [IN_TIME_W-1:0] duration;

  modport source (output valid, output mode, output server, output start_time,
                  output duration, input ready);
  modport sink (input valid, input mode, input server, input start_time,
                input duration, output ready);
endinterface

// File: src/llsa_out_if.sv
`timescale 1ns / 1ps

interface llsa_out_if;
  import llsa_pkg::*;

  logic              valid;
  logic              ready;
  logic [SRV_W-1:0]  chosen_server;
  logic [LOAD_W-1:0] load_after;
  logic [FIN_W-1:0]  finish_after;
  logic [FIN_W-1:0]  max_finish;
  logic              error;

  modport source (output valid, output chosen_server, output load_after,
                  output finish_after, output max_finish, output error, input ready);
  modport sink (input valid, input chosen_server, input load_after,
                input finish_after, input max_finish, input error, output ready);
endinterface

// File: src/llsa_ram.sv
`timescale 1ns / 1ps

module llsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/llsa_ctrl.sv
`timescale 1ns / 1ps

module llsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  llsa_pkg::llsa_sts_t sts,
  output llsa_pkg::llsa_cmd_t cmd
);
  import llsa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_DISPATCH  = 8'b0000_0010,
    S_CLEAR     = 8'b0000_0100,
    S_SCAN      = 8'b0000_1000,
    S_SCAN_LAST = 8'b0001_0000,
    S_READ      = 8'b0010_0000,
    S_CALC      = 8'b0100_0000,
    S_FINISH    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   boot_r, boot_nxt;

  always_comb begin
    state_nxt = state_r;
    boot_nxt  = boot_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.cnt_zero = 1'b1;
        cmd.in_take  = sts.in_valid;
        if (sts.in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.mode)
          MODE_CLEAR:  state_nxt = S_CLEAR;
          MODE_ARRIVE: state_nxt = S_SCAN;
          MODE_DEPART: state_nxt = S_READ;
          default:     state_nxt = S_FINISH;
        endcase
      end
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last_all) begin
          // The sweep after reset produces no result.
          state_nxt = boot_r ? S_IDLE : S_FINISH;
          boot_nxt  = 1'b0;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last_use) begin
          state_nxt = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: state_nxt = S_FINISH;
      S_READ: state_nxt = S_CALC;
      S_CALC: begin
        cmd.dep_calc = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      boot_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      boot_r  <= boot_nxt;
    end
  end

endmodule

// File: src/llsa_dp.sv
`timescale 1ns / 1ps

module llsa_dp #(
  parameter int SERVERS   = llsa_pkg::SERVERS_DEF,
  parameter int TIME_BITS = llsa_pkg::TIME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [llsa_pkg::CFG_W-1:0] cfg_wr_data,
  llsa_in_if.sink                    in_if,
  llsa_out_if.source                 out_if,
  input  llsa_pkg::llsa_cmd_t        cmd,
  output llsa_pkg::llsa_sts_t        sts
);
  import llsa_pkg::*;

  localparam int IDX_W  = $clog2(SERVERS);
  localparam int CNT_W  = $clog2(SERVERS + 1);
  localparam int CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int TM_W   = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
  localparam int WORD_W = LOAD_W + FIN_W;
  localparam logic [IN_TIME_W:0] TMASK = ((IN_TIME_W+1)'(1) << TM_W) - (IN_TIME_W+1)'(1);

  // Latched request.
  logic [MODE_W-1:0]    mode_r;
  logic [SRV_W-1:0]     srv_r;
  logic [IN_TIME_W-1:0] start_r, dur_r;

  logic [CFG_W-1:0] cfg_r;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  // Scan compare stage.
  logic             cmp_en_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [LOAD_W-1:0] best_load_r;
  logic [FIN_W-1:0]  best_fin_r;

  // Departure results.
  logic [LOAD_W-1:0] calc_load_r;
  logic [FIN_W-1:0]  calc_fin_r;
  logic              calc_err_r;

  logic [FIN_W-1:0] largest_r;

  logic              out_valid_r;
  logic [SRV_W-1:0]  out_srv_r;
  logic [LOAD_W-1:0] out_load_r;
  logic [FIN_W-1:0]  out_fin_r;
  logic [FIN_W-1:0]  out_max_r;
  logic              out_err_r;

  logic [CW-1:0]     cfg_ext, n_act, n_m1, srv_ext, cnt_ext;
  logic              in_use, exists, commit, out_free;
  logic [IDX_W+SRV_W-1:0] srv_wide, best_wide;
  logic [IDX_W-1:0]  srv_idx, raddr, waddr;
  logic              we;
  logic [WORD_W-1:0] wdata, rdata;
  logic [LOAD_W-1:0] rd_load, load_inc, dep_load;
  logic [FIN_W-1:0]  rd_fin, base, fin_sat, dep_fin, max_nxt;
  logic [FIN_W:0]    sum;
  logic [IN_TIME_W-1:0] start_m, dur_m;
  logic              dep_err;
  logic [SRV_W-1:0]  res_srv;
  logic [LOAD_W-1:0] res_load;
  logic [FIN_W-1:0]  res_fin;
  logic              res_err;

  // Effective number of servers: zero acts as one, too large acts as all.
  always_comb begin
    cfg_ext = CW'(cfg_r);
    if (cfg_ext == '0) begin
      n_act = CW'(1);
    end else if (cfg_ext > CW'(SERVERS)) begin
      n_act = CW'(SERVERS);
    end else begin
      n_act = cfg_ext;
    end
  end

  assign n_m1     = n_act - CW'(1);
  assign srv_ext  = CW'(srv_r);
  assign cnt_ext  = CW'(cnt_r);
  assign in_use   = srv_ext < n_act;
  assign exists   = srv_ext < CW'(SERVERS);
  assign srv_wide = {{IDX_W{1'b0}}, srv_r};
  assign srv_idx  = srv_wide[IDX_W-1:0];
  assign best_wide = {{SRV_W{1'b0}}, best_idx_r};

  assign out_free = !out_valid_r || out_if.ready;
  assign commit   = cmd.finish && out_free;

  assign sts.in_valid     = in_if.valid;
  assign sts.mode         = mode_r;
  assign sts.cnt_last_all = cnt_r == IDX_W'(SERVERS - 1);
  assign sts.cnt_last_use = cnt_ext == n_m1;
  assign sts.out_free     = out_free;

  assign in_if.ready = cmd.in_ready;

  assign raddr = cmd.scan_rd ? cnt_r : srv_idx;

  llsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SERVERS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_load = rdata[WORD_W-1:FIN_W];
  assign rd_fin  = rdata[FIN_W-1:0];

  // Departure arithmetic on the word just read.
  always_comb begin
    start_m = start_r & TMASK[IN_TIME_W-1:0];
    dur_m   = dur_r & TMASK[IN_TIME_W-1:0];
    base    = (rd_fin > FIN_W'(start_m)) ? rd_fin : FIN_W'(start_m);
    sum     = {1'b0, base} + (FIN_W+1)'(dur_m);
    fin_sat = sum[FIN_W] ? FIN_MAX : sum[FIN_W-1:0];
    if (in_use) begin
      dep_err  = rd_load == '0;
      dep_load = (rd_load == '0) ? rd_load : rd_load - LOAD_W'(1);
      dep_fin  = fin_sat;
    end else if (exists) begin
      dep_err  = 1'b1;
      dep_load = rd_load;
      dep_fin  = rd_fin;
    end else begin
      dep_err  = 1'b1;
      dep_load = '0;
      dep_fin  = '0;
    end
  end

  assign load_inc = (best_load_r == LOAD_MAX) ? best_load_r : best_load_r + LOAD_W'(1);

  always_comb begin
    we       = cmd.clr_wr;
    waddr    = cnt_r;
    wdata    = '0;
    max_nxt  = largest_r;
    res_srv  = '0;
    res_load = '0;
    res_fin  = '0;
    res_err  = 1'b0;
    if (!cmd.clr_wr) begin
      case (mode_r)
        MODE_CLEAR: begin
          we = 1'b0;
        end
        MODE_ARRIVE: begin
          we       = commit;
          waddr    = best_idx_r;
          wdata    = {load_inc, best_fin_r};
          res_srv  = best_wide[SRV_W-1:0];
          res_load = load_inc;
          res_fin  = best_fin_r;
        end
        MODE_DEPART: begin
          we       = commit && in_use;
          waddr    = srv_idx;
          wdata    = {calc_load_r, calc_fin_r};
          res_srv  = srv_r;
          res_load = calc_load_r;
          res_fin  = calc_fin_r;
          res_err  = calc_err_r;
          if (in_use && (calc_fin_r > largest_r)) begin
            max_nxt = calc_fin_r;
          end
        end
        default: begin
          we      = 1'b0;
          res_err = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_zero) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      cnt_r       <= '0;
      cmp_en_r    <= 1'b0;
      largest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      cnt_r    <= cnt_nxt;
      cmp_en_r <= cmd.scan_rd;
      if (cmd.clr_wr) begin
        largest_r <= '0;
      end else if (commit) begin
        largest_r <= max_nxt;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      mode_r  <= in_if.mode;
      srv_r   <= in_if.server;
      start_r <= in_if.start_time;
      dur_r   <= in_if.duration;
    end
    rd_idx_r <= cnt_r;
    // Strict less-than keeps the lowest index on a tie.
    if (cmp_en_r && ((rd_idx_r == '0) || (rd_load < best_load_r))) begin
      best_idx_r  <= rd_idx_r;
      best_load_r <= rd_load;
      best_fin_r  <= rd_fin;
    end
    if (cmd.dep_calc) begin
      calc_load_r <= dep_load;
      calc_fin_r  <= dep_fin;
      calc_err_r  <= dep_err;
    end
    if (commit) begin
      out_srv_r  <= res_srv;
      out_load_r <= res_load;
      out_fin_r  <= res_fin;
      out_max_r  <= max_nxt;
      out_err_r  <= res_err;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.chosen_server = out_srv_r;
  assign out_if.load_after    = out_load_r;
  assign out_if.finish_after  = out_fin_r;
  assign out_if.max_finish    = out_max_r;
  assign out_if.error         = out_err_r;

  // The running maximum only drops during a clearing sweep.
  a_largest_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.clr_wr |=> largest_r >= $past(largest_r))
    else $error("largest finish time decreased outside a clear");

  // No server's finish time can exceed the running maximum.
  a_fin_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_fin_r <= out_max_r)
    else $error("reported finish time exceeds maximum finish");

  // An arrival always lands on a server with at least one job and no error.
  a_arrive_result: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (mode_r == MODE_ARRIVE) |=> !out_err_r && (out_load_r != '0))
    else $error("arrival result carries an error or an empty load");

endmodule

// File: src/least_loaded_server_assign_core.sv
`timescale 1ns / 1ps

// Least-loaded server assignment.
// Requests arrive on in_if (valid/ready): clear, arrive or depart events.
// Each request gives exactly one result on out_if (valid/ready), in order.
// cfg_wr_en/cfg_wr_data set the number of servers in use; write only while idle.
// Sequence from the accepting edge to out_if.valid:
//   arrive: a scan of the N servers in use, one table read per cycle
//           through the single read port of the load/finish RAM, then commit;
//   depart: read, compute, commit; other code: straight to commit;
//   clear:  a sweep of all SERVERS entries, one RAM entry written per cycle.
// A new request is taken in the cycle after a result is registered, so
// requests are handled one at a time.
// After reset the block sweeps every RAM entry to zero with in_if.ready
// low; configuration writes are taken during the sweep.
// When the receiver stalls, the result is held in the output register and a
// further request may be accepted; its result waits until the register frees.
module least_loaded_server_assign_core #(
  parameter int SERVERS   = llsa_pkg::SERVERS_DEF,
  parameter int TIME_BITS = llsa_pkg::TIME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [llsa_pkg::CFG_W-1:0] cfg_wr_data,
  llsa_in_if.sink                    in_if,
  llsa_out_if.source                 out_if
);
  import llsa_pkg::*;

  llsa_cmd_t cmd;
  llsa_sts_t sts;

  llsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  llsa_dp #(
    .SERVERS   (SERVERS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_if       (in_if),
    .out_if      (out_if),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// File: dv/llsa_assign_checker.sv
`timescale 1ns / 1ps

module llsa_assign_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [llsa_pkg::CFG_W-1:0] cfg_wr_data,
  llsa_in_if                         req_mon,
  llsa_out_if                        res_mon,
  output int                         mismatch_count,
  output int                         results_checked
);
  import llsa_pkg::*;

  typedef struct packed {
    logic [SRV_W-1:0]  server;
    logic [LOAD_W-1:0] load;
    logic [FIN_W-1:0]  finish;
    logic [FIN_W-1:0]  max_finish;
    logic              error;
  } assign_result_t;

  logic [LOAD_W-1:0] load_tbl   [SERVERS_DEF];
  logic [FIN_W-1:0]  finish_tbl [SERVERS_DEF];
  logic [FIN_W-1:0]  largest_finish;
  logic [CFG_W-1:0]  servers_cfg;
  assign_result_t    expected_results[$];

  function automatic int servers_active();
    if (servers_cfg == '0) begin
      return 1;
    end
    if (int'(servers_cfg) > SERVERS_DEF) begin
      return SERVERS_DEF;
    end
    return int'(servers_cfg);
  endfunction

  function automatic void wipe_tables();
    int i;
    for (i = 0; i < SERVERS_DEF; i++) begin
      load_tbl[i]   = '0;
      finish_tbl[i] = '0;
    end
    largest_finish = '0;
  endfunction

  // Applies one request to the tracked loads and finish times and returns the
  // result the block owes for it.
  function automatic assign_result_t predict_assignment(
    input logic [MODE_W-1:0]    mode,
    input logic [SRV_W-1:0]     srv,
    input logic [IN_TIME_W-1:0] start_time,
    input logic [IN_TIME_W-1:0] duration
  );
    assign_result_t res;
    int             active;
    int             pick;
    int             i;
    logic [FIN_W-1:0] base;
    logic [FIN_W:0]   sum;
    res    = '0;
    active = servers_active();
    case (mode)
      MODE_CLEAR: begin
        wipe_tables();
      end
      MODE_ARRIVE: begin
        pick = 0;
        for (i = 1; i < active; i++) begin
          if (load_tbl[i] < load_tbl[pick]) begin
            pick = i;
          end
        end
        if (load_tbl[pick] != LOAD_MAX) begin
          load_tbl[pick] = load_tbl[pick] + LOAD_W'(1);
        end
        res.server = pick[SRV_W-1:0];
        res.load   = load_tbl[pick];
        res.finish = finish_tbl[pick];
      end
      MODE_DEPART: begin
        res.server = srv;
        if (int'(srv) >= active) begin
          // A server outside the active set is reported but left untouched.
          res.load   = load_tbl[srv];
          res.finish = finish_tbl[srv];
          res.error  = 1'b1;
        end else begin
          if (load_tbl[srv] == '0) begin
            res.error = 1'b1;
          end else begin
            load_tbl[srv] = load_tbl[srv] - LOAD_W'(1);
          end
          base = finish_tbl[srv];
          if (FIN_W'(start_time) > base) begin
            base = FIN_W'(start_time);
          end
          sum = {1'b0, base} + (FIN_W + 1)'(duration);
          finish_tbl[srv] = sum[FIN_W] ? FIN_MAX : sum[FIN_W-1:0];
          if (finish_tbl[srv] > largest_finish) begin
            largest_finish = finish_tbl[srv];
          end
          res.load   = load_tbl[srv];
          res.finish = finish_tbl[srv];
        end
      end
      default: begin
        res.error = 1'b1;
      end
    endcase
    res.max_finish = largest_finish;
    return res;
  endfunction

  function automatic bit field_ok(input string name, input logic [FIN_W-1:0] want,
                                  input logic [FIN_W-1:0] got);
    if (want === got) begin
      return 1'b1;
    end
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    assign_result_t want;
    assign_result_t got;
    bit             ok;
    if (!rst_n) begin
      wipe_tables();
      servers_cfg = CFG_RESET;
      expected_results.delete();
      mismatch_count  <= 0;
      results_checked <= 0;
    end else begin
      if (cfg_wr_en) begin
        servers_cfg = cfg_wr_data;
      end
      if (res_mon.valid && res_mon.ready) begin
        got.server     = res_mon.chosen_server;
        got.load       = res_mon.load_after;
        got.finish     = res_mon.finish_after;
        got.max_finish = res_mon.max_finish;
        got.error      = res_mon.error;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: server %0d", got.server);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_results.pop_front();
          ok = field_ok("chosen_server", FIN_W'(want.server), FIN_W'(got.server));
          ok &= field_ok("load_after", FIN_W'(want.load), FIN_W'(got.load));
          ok &= field_ok("finish_after", want.finish, got.finish);
          ok &= field_ok("max_finish", want.max_finish, got.max_finish);
          ok &= field_ok("error", FIN_W'(want.error), FIN_W'(got.error));
          if (!ok) begin
            mismatch_count <= mismatch_count + 1;
          end
        end
        results_checked <= results_checked + 1;
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_results.push_back(predict_assignment(req_mon.mode, req_mon.server,
                                                      req_mon.start_time,
                                                      req_mon.duration));
      end
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import llsa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = SERVERS_DEF + 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_REQUESTS = 180;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  llsa_in_if  req_if ();
  llsa_out_if res_if ();

  int mismatch_count;
  int results_checked;
  int requests_sent;
  int arrive_sent;
  int depart_sent;
  int clear_sent;
  int unused_sent;
  int settings_used;
  int hold_off_asked;
  int hold_off_done;

  logic [CFG_W-1:0]     servers_cfg;
  logic [IN_TIME_W-1:0] time_cursor;

  least_loaded_server_assign_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_if       (req_if),
    .out_if      (res_if)
  );

  llsa_assign_checker assign_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .req_mon         (req_if),
    .res_mon         (res_if),
    .mismatch_count  (mismatch_count),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("least_loaded_server_assign_core regression: fail");
    $finish;
  end

  // Result side: random stalls, quiet stretches, and a long hold-off on request.
  initial begin : result_sink
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_asked > hold_off_done) begin
        hold_off_done++;
        res_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 4) == 0) begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end else if ($urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        res_if.ready <= ($urandom_range(0, 2) != 0);
        @(posedge clk);
      end
    end
  end

  task automatic push_request(input logic [MODE_W-1:0] mode, input logic [SRV_W-1:0] srv,
                              input logic [IN_TIME_W-1:0] start_time,
                              input logic [IN_TIME_W-1:0] duration);
    req_if.valid      <= 1'b1;
    req_if.mode       <= mode;
    req_if.server     <= srv;
    req_if.start_time <= start_time;
    req_if.duration   <= duration;
    do @(posedge clk); while (!req_if.ready);
    requests_sent++;
    case (mode)
      MODE_CLEAR:  clear_sent++;
      MODE_ARRIVE: arrive_sent++;
      MODE_DEPART: depart_sent++;
      default:     unused_sent++;
    endcase
  endtask

  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (results_checked != requests_sent) @(posedge clk);
  endtask

  task automatic set_servers_in_use(input logic [CFG_W-1:0] value);
    wait_all_results();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    servers_cfg = value;
    settings_used++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int active_servers();
    if (servers_cfg == '0) begin
      return 1;
    end
    return (int'(servers_cfg) > SERVERS_DEF) ? SERVERS_DEF : int'(servers_cfg);
  endfunction

  // Mostly times that move forward like a real schedule, with extremes mixed in.
  function automatic logic [IN_TIME_W-1:0] pick_time(input bit for_duration);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom();
      default: return for_duration ? IN_TIME_W'($urandom_range(0, 500))
                                   : time_cursor + IN_TIME_W'($urandom_range(0, 200));
    endcase
  endfunction

  task automatic send_random();
    int                roll;
    logic [MODE_W-1:0] mode;
    logic [SRV_W-1:0]  srv;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      mode = MODE_CLEAR;
    end else if (roll < 5) begin
      mode = MODE_UNUSED;
    end else if (roll < 52) begin
      mode = MODE_ARRIVE;
    end else begin
      mode = MODE_DEPART;
    end
    if (mode == MODE_DEPART && $urandom_range(0, 99) < 85) begin
      srv = SRV_W'($urandom_range(0, active_servers() - 1));
    end else begin
      srv = SRV_W'($urandom());
    end
    time_cursor = time_cursor + IN_TIME_W'($urandom_range(0, 40));
    push_request(mode, srv, pick_time(1'b0), pick_time(1'b1));
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] plan [8];
    int               burst_left;
    int               p;
    int               k;
    req_if.valid      <= 1'b0;
    req_if.mode       <= MODE_CLEAR;
    req_if.server     <= '0;
    req_if.start_time <= '0;
    req_if.duration   <= '0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    rst_n             <= 1'b0;
    servers_cfg = CFG_RESET;
    time_cursor = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: ties go to the lowest index, idle departures flag an error.
    push_request(MODE_ARRIVE, '0, '0, '0);
    push_request(MODE_ARRIVE, '1, '1, '1);
    push_request(MODE_DEPART, 6'd0, '0, '0);
    push_request(MODE_DEPART, 6'd0, 32'd100, 32'd7);
    sender_gap($urandom_range(1, 3));
    push_request(MODE_DEPART, 6'd63, '1, '1);
    push_request(MODE_DEPART, 6'd1, 32'd5, 32'd10);
    push_request(MODE_UNUSED, '1, '1, '1);
    push_request(MODE_CLEAR, '1, '1, '1);
    push_request(MODE_ARRIVE, 6'd42, 32'd3, 32'd9);

    // Three servers: assignment wraps, and departures beyond the set are refused.
    set_servers_in_use(7'd3);
    repeat (4) push_request(MODE_ARRIVE, SRV_W'($urandom()), $urandom(), $urandom());
    push_request(MODE_DEPART, 6'd3, 32'd50, 32'd50);
    push_request(MODE_DEPART, 6'd63, 32'd50, 32'd50);
    push_request(MODE_DEPART, 6'd2, 32'd1000, 32'd1);

    // A zero setting behaves as a single server.
    set_servers_in_use(7'd0);
    push_request(MODE_ARRIVE, '0, '0, '0);
    push_request(MODE_ARRIVE, '0, '0, '0);
    push_request(MODE_DEPART, 6'd1, 32'd1, 32'd1);
    push_request(MODE_DEPART, 6'd0, '1, 32'd2);

    // Values above the server count act as the full set.
    set_servers_in_use(7'd127);
    push_request(MODE_ARRIVE, '1, '0, '0);
    push_request(MODE_DEPART, 6'd63, 32'd9, '1);
    push_request(MODE_UNUSED, '0, '0, '0);

    plan = '{7'd1, 7'd2, 7'd64, 7'd127, 7'd0, 7'd0, 7'd0, 7'd0};
    plan[5] = CFG_W'($urandom_range(3, 8));
    plan[6] = CFG_W'($urandom_range(9, 63));
    plan[7] = CFG_W'($urandom_range(0, 127));
    burst_left = 0;
    for (p = 0; p < 8; p++) begin
      set_servers_in_use(plan[p]);
      if (p == 0 || p == 4) begin
        hold_off_asked++;
      end
      for (k = 0; k < PHASE_REQUESTS; k++) begin
        if (burst_left == 0) begin
          sender_gap($urandom_range(1, 12));
          burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
        end
        send_random();
        burst_left--;
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d requests (%0d arrive, %0d depart, %0d clear, %0d unused code)",
             requests_sent, arrive_sent, depart_sent, clear_sent, unused_sent);
    $display("over %0d server-count settings, with long receiver hold-offs; %0d checked.",
             settings_used, results_checked);
    if (mismatch_count == 0) begin
      $display("least_loaded_server_assign_core regression: pass");
    end else begin
      $display("least_loaded_server_assign_core regression: fail");
    end
    $finish;
  end

endmodule
